FILE: src/window_mean_median_ema_filter_assert.svh
// Assertion macros for the windowed mean, median and smoother filter.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef WINDOW_MEAN_MEDIAN_EMA_FILTER_ASSERT_SVH
`define WINDOW_MEAN_MEDIAN_EMA_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define WMF_ASSERT_IMPL(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("wmf assertion failed");
`define WMF_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("wmf assertion failed");
`else
`define WMF_ASSERT_IMPL(label, cond, prop)
`define WMF_ASSERT_NEXT(label, cond, prop)
`endif
`endif

FILE: src/wmf_pkg.sv
// Shared types and constants of the windowed mean, median and smoother filter.
// No dependencies.
package wmf_pkg;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int ALPHA_W    = 17;
	localparam int WIN_W      = 6;
	localparam int MEAN_W     = 24;
	localparam int MED_W      = 17;
	localparam int SMOOTH_W   = 32;
	localparam int COUNT_W    = 6;
	localparam int TOTAL_W    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_WINDOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_WINDOW = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_EMA_A = 8'b00000010,
		ST_EMA_B = 8'b00000100,
		ST_EMA_C = 8'b00001000,
		ST_ROT   = 8'b00010000,
		ST_DIVS  = 8'b00100000,
		ST_MED   = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;
endpackage

FILE: src/wmf_ifs.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Uses wmf_pkg for field widths.
interface wmf_in_if #(parameter int SAMPLE_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   restart;
	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);
endinterface

interface wmf_out_if import wmf_pkg::*; ;
	logic                       valid;
	logic                       ready;
	logic signed [MEAN_W-1:0]   mean_q8;
	logic signed [MED_W-1:0]    median_x2;
	logic signed [SMOOTH_W-1:0] smoothed_q16;
	logic [COUNT_W-1:0]         stored_count;
	logic [TOTAL_W-1:0]         total_points;
	modport source (output valid, output mean_q8, output median_x2, output smoothed_q16,
		output stored_count, output total_points, input ready);
	modport sink (input valid, input mean_q8, input median_x2, input smoothed_q16,
		input stored_count, input total_points, output ready);
endinterface

FILE: src/wmf_hist_cell.sv
// One history cell: shifts in the newest sample or rotates toward cell zero.
// No dependencies.
module wmf_hist_cell #(parameter int SAMPLE_BITS = 16) (
	input  logic                   clk,
	input  logic                   shift,
	input  logic                   rot,
	input  logic [SAMPLE_BITS-1:0] from_left,
	input  logic [SAMPLE_BITS-1:0] from_right,
	output logic [SAMPLE_BITS-1:0] value
);
	logic [SAMPLE_BITS-1:0] value_q;

	// take the newer neighbor on a push, the next one on a rotation
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= from_left;
		end else if (rot) begin
			value_q <= from_right;
		end
	end

	assign value = value_q;
endmodule

FILE: src/wmf_sort_cell.sv
// One insertion-sort cell: keeps its place in an ascending chain.
// No dependencies.
module wmf_sort_cell #(parameter int SAMPLE_BITS = 16) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          ins,
	input  logic signed [SAMPLE_BITS-1:0] ins_val,
	input  logic                          prev_vld,
	input  logic signed [SAMPLE_BITS-1:0] prev_val,
	input  logic                          shl,
	input  logic                          next_vld,
	input  logic signed [SAMPLE_BITS-1:0] next_val,
	output logic                          vld,
	output logic signed [SAMPLE_BITS-1:0] val
);
	logic                          vld_q;
	logic signed [SAMPLE_BITS-1:0] val_q;

	// hold valid flag; a cell fills on an insert only behind a valid neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (ins && prev_vld) begin
			vld_q <= 1'b1;
		end else if (shl) begin
			vld_q <= next_vld;
		end
	end

	// insert: left value if new < left, else new if new < own or empty
	always_ff @(posedge clk) begin
		priority if (ins && prev_vld && (ins_val < prev_val)) begin
			val_q <= prev_val;
		end else if (ins && prev_vld && (!vld_q || (ins_val < val_q))) begin
			val_q <= ins_val;
		end else if (shl) begin
			val_q <= next_val;
		end else begin
			val_q <= val_q;
		end
	end

	assign vld = vld_q;
	assign val = val_q;
endmodule

FILE: src/wmf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module wmf_div #(
	parameter int NUM_W = 30,
	parameter int DEN_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] qd_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, qd_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// count down the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			qd_q  <= {qd_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = qd_q;
endmodule

FILE: src/window_mean_median_ema_filter.sv
// Top level of the windowed mean, median and exponential smoother filter.
// Uses wmf_pkg, wmf_ifs, wmf_hist_cell, wmf_sort_cell, wmf_div and the assert header.
//
//   port     | dir | beat
//   in_ch    | in  | sample, restart
//   out_ch   | out | mean_q8, median_x2, smoothed_q16, stored_count, total_points
//   cfg_*    | in  | register write, no handshake
//
// For each item, one rotation of the history chain feeds the sum and the sort chain, then the
// bit-serial mean divider runs. Reset needs no clearing pass. in_ch.ready is high while no
// item is in flight; a finished result waits in the output register and holds the next
// item's result back only while out_ch stalls.
`include "window_mean_median_ema_filter_assert.svh"
module window_mean_median_ema_filter import wmf_pkg::*; #(
	parameter int HISTORY_DEPTH = 32,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	wmf_in_if.sink                in_ch,
	wmf_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int D   = HISTORY_DEPTH;
	localparam int CW  = $clog2(D + 1);
	localparam int MW  = (CW > WIN_W) ? CW : WIN_W;
	localparam int SW  = SAMPLE_BITS + CW;
	localparam int NW  = SW + 8;
	localparam int SB  = SAMPLE_BITS;
	localparam logic signed [SB-1:0] SORT_FLOOR = {1'b1, {(SB - 1){1'b0}}};

	state_t st_q;

	// configuration
	logic [ALPHA_W-1:0] alpha_q;
	logic [WIN_W-1:0]   mwin_q;
	logic [WIN_W-1:0]   dwin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			mwin_q  <= '0;
			dwin_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_EMA_ALPHA:     alpha_q <= cfg_data[ALPHA_W-1:0];
				CFG_MEAN_WINDOW:   mwin_q  <= cfg_data[WIN_W-1:0];
				CFG_MEDIAN_WINDOW: dwin_q  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	logic in_acc;
	assign in_ch.ready = st_q == ST_IDLE;
	assign in_acc      = in_ch.valid && in_ch.ready;

	// fill level, point total, seeded flag, held sample
	logic [CW-1:0]          fill_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   seeded_q;
	logic signed [SB-1:0]   x_q;
	logic [CW-1:0]          fill_base;
	logic [TOTAL_W-1:0]     total_base;

	assign fill_base  = in_ch.restart ? '0 : fill_q;
	assign total_base = in_ch.restart ? '0 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
		end else if (in_acc) begin
			fill_q  <= (fill_base == CW'(D)) ? fill_base : fill_base + 1'b1;
			total_q <= (total_base == '1) ? total_base : total_base + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= in_ch.sample;
		end
	end

	// window sizes
	logic [MW-1:0] fill_w;
	logic [MW-1:0] mwin_w;
	logic [MW-1:0] dwin_w;
	logic [CW-1:0] nm_q;
	logic [CW-1:0] nd_q;
	assign fill_w = MW'(fill_q);
	assign mwin_w = MW'(mwin_q);
	assign dwin_w = MW'(dwin_q);

	always_ff @(posedge clk) begin
		if (st_q == ST_EMA_A) begin
			nm_q <= (mwin_w == '0 || mwin_w > fill_w) ? fill_q : mwin_w[CW-1:0];
			nd_q <= (dwin_w == '0 || dwin_w > fill_w) ? fill_q : dwin_w[CW-1:0];
		end
	end

	// smoother
	logic signed [63:0]           xw;
	logic signed [SMOOTH_W-1:0]   xq;
	logic [ALPHA_W-1:0]           ca;
	logic signed [49:0]           p1_q;
	logic signed [49:0]           p2_q;
	logic signed [51:0]           acc;
	logic signed [51:0]           shr;
	logic signed [SMOOTH_W-1:0]   ema_new;
	logic signed [SMOOTH_W-1:0]   sm_q;

	assign xw  = $signed({{(48 - SB){x_q[SB-1]}}, x_q, 16'b0});
	assign xq  = (xw > 64'sd2147483647) ? 32'sh7fffffff :
		(xw < -64'sd2147483648) ? 32'sh80000000 : xw[SMOOTH_W-1:0];
	assign ca  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign acc = 52'(p1_q) + 52'(p2_q) + 52'sd32768;
	assign shr = acc >>> 16;
	assign ema_new = (shr > 52'sd2147483647) ? 32'sh7fffffff :
		(shr < -52'sd2147483648) ? 32'sh80000000 : shr[SMOOTH_W-1:0];

	always_ff @(posedge clk) begin
		if (st_q == ST_EMA_A) begin
			p1_q <= $signed({1'b0, ca}) * xq;
		end
		if (st_q == ST_EMA_B) begin
			p2_q <= ($signed(18'd65536) - $signed({1'b0, ca})) * sm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			sm_q     <= '0;
		end else if (in_acc && in_ch.restart) begin
			seeded_q <= 1'b0;
			sm_q     <= '0;
		end else if (st_q == ST_EMA_C) begin
			seeded_q <= 1'b1;
			sm_q     <= seeded_q ? ema_new : xq;
		end
	end

	// history chain, newest at cell zero
	logic [SB-1:0] hv [D];
	logic          rot;
	assign rot = st_q == ST_ROT;

	for (genvar i = 0; i < D; i++) begin : g_hist
		wmf_hist_cell #(.SAMPLE_BITS(SB)) u_cell (
			.clk        (clk),
			.shift      (in_acc),
			.rot        (rot),
			.from_left  ((i == 0) ? in_ch.sample : hv[(i + D - 1) % D]),
			.from_right (hv[(i + 1) % D]),
			.value      (hv[i])
		);
	end

	// rotation count, sum
	logic [CW-1:0]        cnt_q;
	logic signed [SW-1:0] sum_q;
	logic                 rot_last;
	assign rot_last = cnt_q == CW'(D - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (st_q == ST_EMA_C) begin
			cnt_q <= '0;
		end else if (rot) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_EMA_C) begin
			sum_q <= '0;
		end else if (rot && (cnt_q < nm_q)) begin
			sum_q <= sum_q + SW'($signed(hv[0]));
		end
	end

	// sort chain; cell zero sees a valid left neighbor at the most negative value
	logic                 sv_vld [D];
	logic signed [SB-1:0] sv     [D];
	logic                 ins;
	logic                 shl;
	logic [CW-1:0]        sh_q;
	assign ins = rot && (cnt_q < nd_q);
	assign shl = (st_q == ST_MED) && (sh_q != '0);

	for (genvar i = 0; i < D; i++) begin : g_sort
		wmf_sort_cell #(.SAMPLE_BITS(SB)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (in_acc),
			.ins      (ins),
			.ins_val  ($signed(hv[0])),
			.prev_vld ((i == 0) ? 1'b1 : sv_vld[(i + D - 1) % D]),
			.prev_val ((i == 0) ? SORT_FLOOR : sv[(i + D - 1) % D]),
			.shl      (shl),
			.next_vld ((i == D - 1) ? 1'b0 : sv_vld[(i + 1) % D]),
			.next_val (sv[(i + 1) % D]),
			.vld      (sv_vld[i]),
			.val      (sv[i])
		);
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DIVS) begin
			sh_q <= (nd_q - 1'b1) >> 1;
		end else if (shl) begin
			sh_q <= sh_q - 1'b1;
		end
	end

	// mean divider
	logic          neg_q;
	logic [NW-1:0] num;
	logic [NW-1:0] quo;
	logic          div_busy;
	logic [SW-1:0] mag;
	assign mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign num = {mag, 8'b0};

	always_ff @(posedge clk) begin
		if (st_q == ST_DIVS) begin
			neg_q <= sum_q[SW-1];
		end
	end

	wmf_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == ST_DIVS),
		.num    (num),
		.den    (nm_q),
		.busy   (div_busy),
		.quo    (quo)
	);

	// result assembly with saturation
	logic signed [63:0] mean_w;
	logic signed [63:0] med_w;
	logic signed [SB:0] m0;
	logic signed [SB:0] m1;
	logic               out_vld_q;
	logic               out_free;
	logic               finish;
	assign mean_w = neg_q ? -$signed(64'(quo)) : $signed(64'(quo));
	assign m0     = (SB + 1)'(sv[0]);
	assign m1     = (SB + 1)'(sv[(D > 1) ? 1 : 0]);
	assign med_w  = 64'(nd_q[0] ? (m0 <<< 1) : (m0 + m1));
	assign out_free = !out_vld_q || out_ch.ready;
	assign finish   = (st_q == ST_DONE) && !div_busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (finish) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_ch.mean_q8 <= (mean_w > 64'sd8388607) ? 24'sh7fffff :
				(mean_w < -64'sd8388608) ? 24'sh800000 : mean_w[MEAN_W-1:0];
			out_ch.median_x2 <= (med_w > 64'sd65535) ? 17'sh0ffff :
				(med_w < -64'sd65536) ? 17'sh10000 : med_w[MED_W-1:0];
			out_ch.smoothed_q16 <= sm_q;
			out_ch.stored_count <= fill_w[COUNT_W-1:0];
			out_ch.total_points <= total_q;
		end
	end

	assign out_ch.valid = out_vld_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE:  if (in_acc) st_q <= ST_EMA_A;
				ST_EMA_A: st_q <= ST_EMA_B;
				ST_EMA_B: st_q <= ST_EMA_C;
				ST_EMA_C: st_q <= ST_ROT;
				ST_ROT:   if (rot_last) st_q <= ST_DIVS;
				ST_DIVS:  st_q <= ST_MED;
				ST_MED:   if (sh_q == '0) st_q <= ST_DONE;
				ST_DONE:  if (finish) st_q <= ST_IDLE;
				default:  st_q <= ST_IDLE;
			endcase
		end
	end

	`WMF_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready)
	`WMF_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CW'(D))
	`WMF_ASSERT_NEXT(a_sort_first, rot && (cnt_q == '0), sv_vld[0])
endmodule
